@@ design/dbd_pkg.sv @@
// Shared types, codes and id lookup tables for the D-BUS packet deframer.
// No dependencies; used by dbd_parse and dbus_packet_deframer.
package dbd_pkg;

	localparam logic [7:0] START_BYTE   = 8'h98;
	localparam logic [7:0] RESYNC_CMD_A = 8'h15;
	localparam logic [7:0] RESYNC_CMD_B = 8'h56;

	typedef logic [4:0] cmd_idx_t;
	// Table position given to a command id that is not in the table
	localparam cmd_idx_t CMD_UNKNOWN = 5'd18;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_DATA,
		PH_CKLOW,
		PH_CKHIGH
	} phase_t;

	typedef enum logic [2:0] {
		KIND_HEADER   = 3'd0,
		KIND_DATA     = 3'd1,
		KIND_CHECKSUM = 3'd2,
		KIND_ERROR    = 3'd3,
		KIND_WARNING  = 3'd4
	} kind_t;

	typedef enum logic {
		ERR_MACHINE = 1'b0,
		ERR_COMMAND = 1'b1
	} err_t;

	typedef struct packed {
		logic        valid;
		kind_t       kind;
		logic        direction;
		logic [7:0]  machine;
		cmd_idx_t    command;
		logic [15:0] length;
		logic [7:0]  data;
		logic        last;
		logic [15:0] checksum;
		err_t        error;
	} dbd_result_t;

	// Machine ids sent by the calculator side
	function automatic logic mach_upper(input logic [7:0] b);
		logic r;
		case (b) inside
			8'h82, 8'h83, 8'h85, 8'h86, 8'h74, 8'h98, 8'h88, 8'h89, 8'h73: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic mach_known(input logic [7:0] b);
		logic r;
		case (b) inside
			8'h00, 8'h02, 8'h03, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h23: r = 1'b1;
			default: r = mach_upper(b);
		endcase
		return r;
	endfunction

	function automatic cmd_idx_t cmd_lookup(input logic [7:0] b);
		cmd_idx_t r;
		case (b)
			8'h06:   r = 5'd0;
			8'h09:   r = 5'd1;
			8'h15:   r = 5'd2;
			8'h2d:   r = 5'd3;
			8'h36:   r = 5'd4;
			8'h47:   r = 5'd5;
			8'h56:   r = 5'd6;
			8'h5a:   r = 5'd7;
			8'h68:   r = 5'd8;
			8'h6d:   r = 5'd9;
			8'h74:   r = 5'd10;
			8'h78:   r = 5'd11;
			8'h87:   r = 5'd12;
			8'h88:   r = 5'd13;
			8'h92:   r = 5'd14;
			8'ha2:   r = 5'd15;
			8'hb7:   r = 5'd16;
			8'hc9:   r = 5'd17;
			default: r = CMD_UNKNOWN;
		endcase
		return r;
	endfunction

	function automatic logic cmd_has_data(input cmd_idx_t idx);
		logic r;
		case (idx) inside
			5'd0, 5'd2, 5'd4, 5'd5, 5'd7, 5'd13, 5'd15, 5'd16, 5'd17: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

@@ design/dbus_packet_deframer.sv @@
// D-BUS packet deframer top level; uses dbd_pkg and dbd_parse.
// An accepted byte is captured in the input register, parsed there, and its result is
// loaded into the result register, which raises out_valid. Throughput: one link byte
// per cycle while no result stalls; the input register empties whenever the result
// register is free or being taken, so a stalled result still lets one byte in.
// Reset (arst_n low, asynchronous): header phase, all counters cleared, resync off.
module dbus_packet_deframer import dbd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	// link bytes in
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  link_byte,
	// results out
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  result_kind,
	output logic        direction,
	output logic [7:0]  machine_byte,
	output logic [4:0]  command_index,
	output logic [15:0] packet_length,
	output logic [7:0]  data_byte,
	output logic        last_data,
	output logic [15:0] checksum_value,
	output logic        error_code
);

	logic        resync_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        advance;
	dbd_result_t res;
	dbd_result_t res_ld;
	dbd_result_t out_q;

	// The result register is free when empty or when its beat leaves this cycle.
	assign advance  = !out_q.valid || !out_stall;
	// Hold the input beat only while it cannot move into the parser.
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			resync_q <= 1'b0;
		else if (cfg_wr_en)
			resync_q <= cfg_wr_data;
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid)
			byte_s1 <= link_byte;
	end

	// Parser: state advances once per input beat that moves on.
	dbd_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (valid_s1 && advance),
		.byte_in (byte_s1),
		.resync  (resync_q),
		.res     (res)
	);

	// A beat without a result leaves the result register empty.
	always_comb begin
		res_ld       = res;
		res_ld.valid = valid_s1 && res.valid;
	end

	// Result register: load when free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (advance) begin
			out_q <= res_ld;
		end
	end

	assign out_valid      = out_q.valid;
	assign result_kind    = out_q.kind;
	assign direction      = out_q.direction;
	assign machine_byte   = out_q.machine;
	assign command_index  = out_q.command;
	assign packet_length  = out_q.length;
	assign data_byte      = out_q.data;
	assign last_data      = out_q.last;
	assign checksum_value = out_q.checksum;
	assign error_code     = out_q.error;

	// An error result carries no direction or command.
	a_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_ERROR |-> !direction && command_index == 5'd0)
		else $error("error result with direction or command set");

	// Command index stays within the table.
	a_cmd_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> command_index < CMD_UNKNOWN)
		else $error("command index out of table");

	// The last-byte mark belongs to data results only.
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_data |-> result_kind == KIND_DATA)
		else $error("last mark on non-data result");

	// Nothing follows an error until reset.
	a_halt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && result_kind == KIND_ERROR |=> !out_valid)
		else $error("result after error");

endmodule

@@ design/dbd_parse.sv @@
// Packet parser: phase state machine, header/data/checksum state and result build.
// Depends on dbd_pkg.
module dbd_parse import dbd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  byte_in,
	input  logic        resync,
	output dbd_result_t res
);

	phase_t      phase_q, phase_d;
	logic [1:0]  hcount_q, hcount_d;
	logic [7:0]  machine_q, machine_d;
	cmd_idx_t    command_q, command_d;
	logic [15:0] length_q, length_d;
	logic [15:0] dcount_q, dcount_d;
	logic [7:0]  held_q, held_d;
	logic        held_valid_q, held_valid_d;
	logic [7:0]  ck_low_q, ck_low_d;
	logic        halted_q, halted_d;

	logic        embedded;
	logic [16:0] dcount_inc;
	logic [15:0] length_full;
	logic        header_bad;

	assign embedded    = resync && held_q == START_BYTE
	                     && (byte_in == RESYNC_CMD_A || byte_in == RESYNC_CMD_B);
	assign dcount_inc  = {1'b0, dcount_q} + 17'd1;
	assign length_full = {byte_in, length_q[7:0]};
	assign header_bad  = !mach_known(machine_q) || command_q == CMD_UNKNOWN;

	// Next state
	always_comb begin
		phase_d      = phase_q;
		hcount_d     = hcount_q;
		machine_d    = machine_q;
		command_d    = command_q;
		length_d     = length_q;
		dcount_d     = dcount_q;
		held_d       = held_q;
		held_valid_d = held_valid_q;
		ck_low_d     = ck_low_q;
		halted_d     = halted_q;
		if (!halted_q) begin
			case (phase_q)
				PH_DATA: begin
					if (held_valid_q) begin
						if (embedded) begin
							phase_d      = PH_HEADER;
							machine_d    = START_BYTE;
							command_d    = cmd_lookup(byte_in);
							length_d     = '0;
							hcount_d     = 2'd2;
							held_valid_d = 1'b0;
							dcount_d     = '0;
						end else if (dcount_q < length_q) begin
							held_d   = byte_in;
							dcount_d = dcount_inc[15:0];
						end else begin
							held_valid_d = 1'b0;
							ck_low_d     = byte_in;
							phase_d      = PH_CKHIGH;
						end
					end else if (resync) begin
						held_d       = byte_in;
						held_valid_d = 1'b1;
						dcount_d     = dcount_inc[15:0];
					end else begin
						dcount_d = dcount_inc[15:0];
						if (dcount_inc >= {1'b0, length_q})
							phase_d = PH_CKLOW;
					end
				end
				PH_CKLOW: begin
					ck_low_d = byte_in;
					phase_d  = PH_CKHIGH;
				end
				PH_CKHIGH: begin
					phase_d  = PH_HEADER;
					hcount_d = 2'd0;
				end
				default: begin
					case (hcount_q)
						2'd0: begin
							machine_d = byte_in;
							hcount_d  = 2'd1;
						end
						2'd1: begin
							command_d = cmd_lookup(byte_in);
							hcount_d  = 2'd2;
						end
						2'd2: begin
							length_d = {8'd0, byte_in};
							hcount_d = 2'd3;
						end
						default: begin
							length_d = length_full;
							hcount_d = 2'd0;
							if (header_bad) begin
								halted_d = 1'b1;
							end else if (cmd_has_data(command_q) && length_full != 16'd0) begin
								phase_d      = PH_DATA;
								dcount_d     = '0;
								held_valid_d = 1'b0;
							end
						end
					endcase
				end
			endcase
		end
	end

	// Result for the current beat
	always_comb begin
		res           = '0;
		res.direction = mach_upper(machine_q);
		res.machine   = machine_q;
		res.command   = (command_q == CMD_UNKNOWN) ? '0 : command_q;
		res.length    = length_q;
		res.kind      = KIND_HEADER;
		res.error     = ERR_MACHINE;
		if (!halted_q) begin
			case (phase_q)
				PH_DATA: begin
					if (held_valid_q) begin
						res.valid = 1'b1;
						if (embedded) begin
							res.kind = KIND_WARNING;
						end else begin
							res.kind = KIND_DATA;
							res.data = held_q;
							res.last = dcount_q >= length_q;
						end
					end else if (!resync) begin
						res.valid = 1'b1;
						res.kind  = KIND_DATA;
						res.data  = byte_in;
						res.last  = dcount_inc >= {1'b0, length_q};
					end
				end
				PH_CKLOW: res.valid = 1'b0;
				PH_CKHIGH: begin
					res.valid    = 1'b1;
					res.kind     = KIND_CHECKSUM;
					res.checksum = {byte_in, ck_low_q};
				end
				default: begin
					if (hcount_q == 2'd3) begin
						res.valid  = 1'b1;
						res.length = length_full;
						if (header_bad) begin
							res.kind      = KIND_ERROR;
							res.direction = 1'b0;
							res.command   = '0;
							res.error     = mach_known(machine_q) ? ERR_COMMAND : ERR_MACHINE;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEADER;
			hcount_q     <= '0;
			machine_q    <= '0;
			command_q    <= '0;
			length_q     <= '0;
			dcount_q     <= '0;
			held_q       <= '0;
			held_valid_q <= 1'b0;
			ck_low_q     <= '0;
			halted_q     <= 1'b0;
		end else if (step) begin
			phase_q      <= phase_d;
			hcount_q     <= hcount_d;
			machine_q    <= machine_d;
			command_q    <= command_d;
			length_q     <= length_d;
			dcount_q     <= dcount_d;
			held_q       <= held_d;
			held_valid_q <= held_valid_d;
			ck_low_q     <= ck_low_d;
			halted_q     <= halted_d;
		end
	end

endmodule
